// File: hdl/lsp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED strip PWM encoder package
// Shared sizes, opcodes, register indexes and the slot descriptor that
// travels from the frame sequencer to the encoder.
// ---------------------------------------------------------------------------
package lsp_pkg;

   // Number of pixels in the chain and the address width of the pixel store.
   localparam int LED_COUNT   = 64;
   localparam int LED_IDX_W   = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

   // Serial format: 24 bits per LED, green, red, blue, MSB first.
   localparam int BITS_PER_LED = 24;
   localparam int BIT_CNT_W    = 5;
   localparam int PIXEL_W      = 24;

   // Register widths.
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   // Register reset values.
   localparam logic [7:0]  BRIGHTNESS_RST  = 8'd255;
   localparam logic [15:0] ONE_CMP_RST     = 16'd58;
   localparam logic [15:0] ZERO_CMP_RST    = 16'd29;
   localparam logic [7:0]  RESET_SLOTS_RST = 8'd50;

   // Request opcodes; code 3 is unused and does nothing.
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_CLEAR = 2'd1,
      OP_SLOT  = 2'd2
   } opcode_type;

   // Register indexes of the write port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BRIGHTNESS  = 2'd0,
      CSR_ONE_CMP     = 2'd1,
      CSR_ZERO_CMP    = 2'd2,
      CSR_RESET_SLOTS = 2'd3
   } csr_index_type;

   // Colour byte in transmit order.
   localparam logic [1:0] BYTE_GREEN = 2'd0;
   localparam logic [1:0] BYTE_RED   = 2'd1;
   localparam logic [1:0] BYTE_BLUE  = 2'd2;

   // Description of one slot, handed from the sequencer to the encoder.
   typedef struct packed {
      logic       gap;       // slot is in the trailing reset gap
      logic       last;      // final reset slot of the frame
      logic [1:0] byte_sel;  // colour byte being sent
      logic [2:0] bit_pos;   // bit within the byte, 0 is the MSB
   } slot_info_type;

endpackage

// File: hdl/lsp_pixel_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED strip pixel store
// Synchronous pixel memory with one write and one registered read port.
// Per-entry valid bits let a clear drop the whole store at once.
// ---------------------------------------------------------------------------
module lsp_pixel_ram
   import lsp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [LED_IDX_W-1:0] wr_addr,
   input  logic [PIXEL_W-1:0]   wr_data,
   input  logic                 clear,
   input  logic                 rd_en,
   input  logic [LED_IDX_W-1:0] rd_addr,
   output logic [PIXEL_W-1:0]   rd_data
);

   logic [PIXEL_W-1:0] mem [LED_COUNT];
   logic [LED_COUNT-1:0] valid_ff;
   logic [LED_COUNT-1:0] valid_in;
   logic [PIXEL_W-1:0]   rd_data_ff;
   logic                 rd_valid_ff;

   // Memory array write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Valid bits: a write marks its entry, a clear drops every entry.
   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // An entry that was cleared or never written reads as black.
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: hdl/lsp_frame_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED strip frame sequencer
// Tracks the frame position as LED, bit and reset gap counters and
// describes the current slot; steps once per slot request.
// ---------------------------------------------------------------------------
module lsp_frame_seq
   import lsp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [7:0]           reset_slot_count,
   output slot_info_type        slot_info,
   output logic [LED_IDX_W-1:0] led_addr
);

   localparam logic [LED_IDX_W-1:0] LAST_LED = LED_IDX_W'(LED_COUNT - 1);
   localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_LED - 1);

   logic                 gap_ff, gap_in;
   logic [LED_IDX_W-1:0] led_ff, led_in;
   logic [BIT_CNT_W-1:0] bit_ff, bit_in;
   logic [7:0]           gap_cnt_ff, gap_cnt_in;
   logic [7:0]           last_gap;
   logic                 gap_last;

   // A reset count of zero behaves as one.
   assign last_gap = (reset_slot_count == 8'd0) ? 8'd0 : reset_slot_count - 8'd1;
   assign gap_last = gap_cnt_ff >= last_gap;

   // Slot description for the current position.
   always_comb begin
      slot_info.gap      = gap_ff;
      slot_info.last     = gap_ff & gap_last;
      slot_info.byte_sel = bit_ff[4:3];
      slot_info.bit_pos  = bit_ff[2:0];
   end

   assign led_addr = led_ff;

   // Next frame position.
   always_comb begin
      gap_in     = gap_ff;
      led_in     = led_ff;
      bit_in     = bit_ff;
      gap_cnt_in = gap_cnt_ff;
      if (advance) begin
         if (!gap_ff) begin
            if (bit_ff == LAST_BIT) begin
               bit_in = '0;
               if (led_ff == LAST_LED) begin
                  gap_in     = 1'b1;
                  gap_cnt_in = '0;
               end else begin
                  led_in = led_ff + LED_IDX_W'(1);
               end
            end else begin
               bit_in = bit_ff + BIT_CNT_W'(1);
            end
         end else if (gap_last) begin
            gap_in = 1'b0;
            led_in = '0;
            bit_in = '0;
         end else begin
            gap_cnt_in = gap_cnt_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff     <= 1'b0;
         led_ff     <= '0;
         bit_ff     <= '0;
         gap_cnt_ff <= '0;
      end else begin
         gap_ff     <= gap_in;
         led_ff     <= led_in;
         bit_ff     <= bit_in;
         gap_cnt_ff <= gap_cnt_in;
      end
   end

endmodule

// File: hdl/lsp_slot_encode.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED strip slot encoder
// Waits for the pixel read, scales the selected colour byte, picks the
// compare value for the bit and holds the result beat for the output.
// ---------------------------------------------------------------------------
module lsp_slot_encode
   import lsp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               issue,
   input  slot_info_type      slot_info,
   input  logic [PIXEL_W-1:0] pixel,
   input  logic [7:0]         brightness,
   input  logic [15:0]        one_bit_compare,
   input  logic [15:0]        zero_bit_compare,
   output logic               busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_compare_value,
   output logic               rsp_in_reset_gap,
   output logic               rsp_frame_last
);

   logic          lookup_valid_ff, lookup_valid_in;
   slot_info_type info_ff;
   logic          out_valid_ff, out_valid_in;
   logic [15:0]   cmp_ff, cmp_in;
   logic          gap_out_ff;
   logic          last_out_ff;
   logic          out_free;
   logic          move;
   logic [7:0]    color_byte;
   logic [15:0]   product;
   logic [7:0]    scaled;
   logic          data_bit;

   // The lookup stage moves on once the output register is free.
   assign out_free = !out_valid_ff || !rsp_stall;
   assign move     = lookup_valid_ff && out_free;
   assign busy     = lookup_valid_ff;

   // Select the colour byte and scale it by the brightness.
   always_comb begin
      case (info_ff.byte_sel)
         BYTE_GREEN: color_byte = pixel[23:16];
         BYTE_RED:   color_byte = pixel[15:8];
         BYTE_BLUE:  color_byte = pixel[7:0];
         default:    color_byte = 8'd0;
      endcase
      product  = 16'(color_byte) * 16'(brightness);
      scaled   = product[15:8];
      data_bit = scaled[~info_ff.bit_pos];
   end

   // Compare value: zero in the reset gap, else by the data bit.
   always_comb begin
      if (info_ff.gap) begin
         cmp_in = 16'd0;
      end else if (data_bit) begin
         cmp_in = one_bit_compare;
      end else begin
         cmp_in = zero_bit_compare;
      end
   end

   // Stage valid flags.
   always_comb begin
      lookup_valid_in = lookup_valid_ff;
      if (issue) begin
         lookup_valid_in = 1'b1;
      end else if (move) begin
         lookup_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (move) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lookup_valid_ff <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         lookup_valid_ff <= lookup_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (issue) begin
         info_ff <= slot_info;
      end
      if (move) begin
         cmp_ff      <= cmp_in;
         gap_out_ff  <= info_ff.gap;
         last_out_ff <= info_ff.last;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_compare_value = cmp_ff;
   assign rsp_in_reset_gap  = gap_out_ff;
   assign rsp_frame_last    = last_out_ff;

endmodule

// File: hdl/rgb_led_strip_pwm_encoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RGB LED strip PWM encoder
// Pixel store plus slot sequencer that turns a serial RGB LED frame into
// one PWM compare value per timer slot.
// ---------------------------------------------------------------------------
// Pixel writes and clears are accepted back to back; a clear drops every
// pixel at once. A slot request first reads the pixel store, then scales
// the colour byte and picks the compare value; a slot lookup in flight
// holds off the next request beat. The output register lets one slot wait
// on a stalled output while the next is looked up. Frames send LED_COUNT
// pixels of 24 bits, green, red, blue, MSB first, then reset_slot_count
// zero slots (at least one), the last one flagged. Register changes take
// effect on the next slot.
// ---------------------------------------------------------------------------
module rgb_led_strip_pwm_encoder
   import lsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_opcode,
   input  logic [7:0]            req_pixel_index,
   input  logic [7:0]            req_red,
   input  logic [7:0]            req_green,
   input  logic [7:0]            req_blue,
   // Result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_compare_value,
   output logic                  rsp_in_reset_gap,
   output logic                  rsp_frame_last,
   // Register write port
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [7:0]  brightness_ff;
   logic [15:0] one_cmp_ff;
   logic [15:0] zero_cmp_ff;
   logic [7:0]  reset_slots_ff;

   logic                 accept;
   logic                 do_write;
   logic                 do_clear;
   logic                 do_slot;
   logic                 in_range;
   logic                 busy;
   slot_info_type        slot_info;
   logic [LED_IDX_W-1:0] led_addr;
   logic [PIXEL_W-1:0]   pixel;

   // Control and status registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff  <= BRIGHTNESS_RST;
         one_cmp_ff     <= ONE_CMP_RST;
         zero_cmp_ff    <= ZERO_CMP_RST;
         reset_slots_ff <= RESET_SLOTS_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BRIGHTNESS:  brightness_ff  <= csr_data[7:0];
            CSR_ONE_CMP:     one_cmp_ff     <= csr_data;
            CSR_ZERO_CMP:    zero_cmp_ff    <= csr_data;
            CSR_RESET_SLOTS: reset_slots_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Request decode; a slot lookup in flight holds off the next beat.
   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign in_range  = 32'(req_pixel_index) < LED_COUNT;
   assign do_write  = accept && (req_opcode == OP_WRITE) && in_range;
   assign do_clear  = accept && (req_opcode == OP_CLEAR);
   assign do_slot   = accept && (req_opcode == OP_SLOT);

   lsp_pixel_ram u_pixel_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (do_write),
      .wr_addr (LED_IDX_W'(req_pixel_index)),
      .wr_data ({req_green, req_red, req_blue}),
      .clear   (do_clear),
      .rd_en   (do_slot && !slot_info.gap),
      .rd_addr (led_addr),
      .rd_data (pixel)
   );

   lsp_frame_seq u_frame_seq (
      .clock            (clock),
      .reset            (reset),
      .advance          (do_slot),
      .reset_slot_count (reset_slots_ff),
      .slot_info        (slot_info),
      .led_addr         (led_addr)
   );

   lsp_slot_encode u_slot_encode (
      .clock             (clock),
      .reset             (reset),
      .issue             (do_slot),
      .slot_info         (slot_info),
      .pixel             (pixel),
      .brightness        (brightness_ff),
      .one_bit_compare   (one_cmp_ff),
      .zero_bit_compare  (zero_cmp_ff),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_compare_value (rsp_compare_value),
      .rsp_in_reset_gap  (rsp_in_reset_gap),
      .rsp_frame_last    (rsp_frame_last)
   );

endmodule

// File: tb/sv/rgb_led_strip_pwm_encoder_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RGB LED strip PWM encoder testbench
// Drives pixel writes, clears and slot requests into the encoder and checks
// every compare value and gap flag against a cycle-free slot encoder kept in
// the bench. A short stimulus table comes first. Random phases follow, each
// with its own register setting, the register extremes first.
// ---------------------------------------------------------------------------
module rgb_led_strip_pwm_encoder_tb;
   import lsp_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int         DATA_SLOTS = LED_COUNT * BITS_PER_LED;
   localparam int         RAND_ITEMS = 730;
   localparam int         LOG_LIMIT  = 50;
   localparam int         NUM_ROWS   = 20;

   // One expected slot beat.
   typedef struct packed {
      logic [15:0] compare_value;
      logic        reset_gap;
      logic        frame_last;
   } slot_result_t;

   // One row of the directed stimulus; typed rows carry their own answer.
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  idx;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        typed;
      logic [15:0] compare_value;
   } stim_row_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_opcode;
   logic [7:0]            req_pixel_index;
   logic [7:0]            req_red;
   logic [7:0]            req_green;
   logic [7:0]            req_blue;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [15:0]           rsp_compare_value;
   logic                  rsp_in_reset_gap;
   logic                  rsp_frame_last;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Bench copy of the encoder state and registers.
   logic [23:0]  pix_mem [LED_COUNT];
   int unsigned  frame_pos;
   logic [7:0]   bright_reg;
   logic [15:0]  one_cmp_reg;
   logic [15:0]  zero_cmp_reg;
   logic [7:0]   reset_slots_reg;

   slot_result_t pending_slots [$];
   int unsigned  idle_max;
   int unsigned  mismatch_count = 0;
   int unsigned  slot_count = 0;
   int unsigned  gap_slot_count = 0;
   int unsigned  wrap_count = 0;
   int unsigned  write_count = 0;
   int unsigned  clear_count = 0;
   int unsigned  setting_count = 0;

   // Directed rows, run with the reset register values.
   stim_row_t directed_rows [NUM_ROWS] = '{
      '{OP_SLOT,   8'd0,   8'h00, 8'h00, 8'h00, 1'b1, ZERO_CMP_RST},
      '{OP_WRITE,  8'd0,   8'h00, 8'hFF, 8'h00, 1'b0, 16'd0},
      '{OP_SLOT,   8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 16'd0},
      '{OP_SLOT,   8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 16'd0},
      '{OP_WRITE,  8'd63,  8'hFF, 8'h00, 8'hFF, 1'b0, 16'd0},
      '{OP_WRITE,  8'd64,  8'hFF, 8'hFF, 8'hFF, 1'b0, 16'd0},
      '{OP_WRITE,  8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b0, 16'd0},
      '{OP_UNUSED, 8'd0,   8'hFF, 8'hFF, 8'hFF, 1'b0, 16'd0},
      '{OP_SLOT,   8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 16'd0},
      '{OP_CLEAR,  8'hFF,  8'hFF, 8'hFF, 8'hFF, 1'b0, 16'd0},
      '{OP_SLOT,   8'd0,   8'h00, 8'h00, 8'h00, 1'b1, ZERO_CMP_RST},
      '{OP_WRITE,  8'd0,   8'h55, 8'hAA, 8'hFF, 1'b0, 16'd0},
      '{OP_SLOT,   8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 16'd0},
      '{OP_SLOT,   8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 16'd0},
      '{OP_SLOT,   8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 16'd0},
      '{OP_SLOT,   8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 16'd0},
      '{OP_SLOT,   8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 16'd0},
      '{OP_SLOT,   8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 16'd0},
      '{OP_WRITE,  8'd1,   8'hFF, 8'hFF, 8'hFF, 1'b0, 16'd0},
      '{OP_SLOT,   8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 16'd0}
   };

   rgb_led_strip_pwm_encoder u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_pixel_index   (req_pixel_index),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_compare_value (rsp_compare_value),
      .rsp_in_reset_gap  (rsp_in_reset_gap),
      .rsp_frame_last    (rsp_frame_last),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   // Prints one mismatch line and counts it; the printout is capped.
   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= LOG_LIMIT) begin
         $display("[%0t] MISMATCH: %s", $realtime, what);
      end
   endtask

   // Colour byte scaled by the global brightness.
   function automatic logic [7:0] scale_byte(input logic [7:0] c);
      logic [15:0] prod;
      prod = 16'(c) * 16'(bright_reg);
      return prod[15:8];
   endfunction

   // Applies one accepted request to the bench state and yields the slot beat
   // that it causes, if any.
   task automatic encode_request(input logic [1:0] op, input logic [7:0] idx,
                                 input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b, output logic has_res,
                                 output slot_result_t res);
      int unsigned led_n;
      int unsigned bit_n;
      int unsigned gap_n;
      int unsigned cnt;
      int          i;
      logic [23:0] px;
      logic [23:0] colour;
      has_res = 1'b0;
      res     = '0;
      case (op)
         OP_WRITE: begin
            write_count++;
            if (idx < LED_COUNT) begin
               pix_mem[idx] = {g, r, b};
            end
         end
         OP_CLEAR: begin
            clear_count++;
            for (i = 0; i < LED_COUNT; i++) begin
               pix_mem[i] = '0;
            end
         end
         OP_SLOT: begin
            has_res = 1'b1;
            slot_count++;
            if (frame_pos < DATA_SLOTS) begin
               // Data slot: one bit of the scaled G, R, B word, MSB first.
               led_n  = frame_pos / BITS_PER_LED;
               bit_n  = (BITS_PER_LED - 1) - (frame_pos % BITS_PER_LED);
               px     = pix_mem[led_n];
               colour = {scale_byte(px[23:16]), scale_byte(px[15:8]),
                         scale_byte(px[7:0])};
               res.compare_value = colour[bit_n] ? one_cmp_reg : zero_cmp_reg;
               frame_pos++;
            end else begin
               // Reset gap: a zero count behaves as one slot, and a count
               // lowered below the current slot ends the frame at once.
               gap_slot_count++;
               gap_n = frame_pos - DATA_SLOTS;
               cnt   = (reset_slots_reg == 8'd0) ? 1 : reset_slots_reg;
               res.reset_gap  = 1'b1;
               res.frame_last = (gap_n >= cnt - 1);
               if (res.frame_last) begin
                  wrap_count++;
                  frame_pos = 0;
               end else begin
                  frame_pos++;
               end
            end
         end
         default: ;
      endcase
   endtask

   // Sends one request beat after a random gap and records what it causes.
   // Entered and left at a falling edge.
   task automatic send_request(input logic [1:0] op, input logic [7:0] idx,
                               input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic typed,
                               input logic [15:0] typed_cmp);
      int unsigned  wait_n;
      logic         has_res;
      slot_result_t res;
      wait_n = $urandom_range(0, idle_max);
      if (wait_n != 0) begin
         req_valid <= 1'b0;
         repeat (wait_n) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_pixel_index <= idx;
      req_red         <= r;
      req_green       <= g;
      req_blue        <= b;
      do @(posedge clock); while (req_stall);
      encode_request(op, idx, r, g, b, has_res, res);
      if (has_res) begin
         if (typed) begin
            res = '{compare_value: typed_cmp, reset_gap: 1'b0, frame_last: 1'b0};
         end
         pending_slots.push_back(res);
      end
      @(negedge clock);
   endtask

   // Holds off the sender until every slot beat is back, then lets the
   // pipeline settle. Entered and left at a falling edge.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_slots.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes all four registers, one beat each, and mirrors them.
   task automatic program_regs(input logic [15:0] bright, input logic [15:0] one_cmp,
                               input logic [15:0] zero_cmp, input logic [15:0] slots);
      csr_write <= 1'b1;
      csr_index <= CSR_BRIGHTNESS;
      csr_data  <= bright;
      @(negedge clock);
      csr_index <= CSR_ONE_CMP;
      csr_data  <= one_cmp;
      @(negedge clock);
      csr_index <= CSR_ZERO_CMP;
      csr_data  <= zero_cmp;
      @(negedge clock);
      csr_index <= CSR_RESET_SLOTS;
      csr_data  <= slots;
      @(negedge clock);
      csr_write <= 1'b0;
      bright_reg      = bright[7:0];
      one_cmp_reg     = one_cmp;
      zero_cmp_reg    = zero_cmp;
      reset_slots_reg = slots[7:0];
      setting_count++;
   endtask

   // Register value with the extremes drawn often.
   function automatic logic [15:0] pick_reg_value();
      int unsigned sel;
      sel = $urandom_range(0, 3);
      if (sel == 0) begin
         return 16'h0000;
      end else if (sel == 1) begin
         return 16'hFFFF;
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   // Result side: random stall before each beat, then take it.
   initial begin
      int unsigned wait_n;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         wait_n = $urandom_range(0, idle_max);
         if (wait_n != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Result checker: each accepted beat against the oldest expectation.
   always @(posedge clock) begin
      slot_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_slots.size() == 0) begin
            report_mismatch($sformatf("unexpected slot beat cmp=%0d gap=%0b last=%0b",
                                      rsp_compare_value, rsp_in_reset_gap,
                                      rsp_frame_last));
         end else begin
            want = pending_slots.pop_front();
            if (rsp_compare_value !== want.compare_value ||
                rsp_in_reset_gap !== want.reset_gap ||
                rsp_frame_last !== want.frame_last) begin
               report_mismatch($sformatf(
                  "slot got cmp=%0d gap=%0b last=%0b, want cmp=%0d gap=%0b last=%0b",
                  rsp_compare_value, rsp_in_reset_gap, rsp_frame_last,
                  want.compare_value, want.reset_gap, want.frame_last));
            end
         end
      end
   end

   // Main sequence: reset, directed rows, then random phases.
   initial begin
      int          i;
      int unsigned phase;
      int unsigned budget;
      int unsigned phase_items;
      int unsigned rand_items;
      int unsigned sel;
      logic [1:0]  op;
      logic [7:0]  idx;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OP_SLOT;
      req_pixel_index = '0;
      req_red         = '0;
      req_green       = '0;
      req_blue        = '0;
      csr_write       = 1'b0;
      csr_index       = CSR_BRIGHTNESS;
      csr_data        = '0;
      idle_max        = 11;
      for (i = 0; i < LED_COUNT; i++) begin
         pix_mem[i] = '0;
      end
      frame_pos       = 0;
      bright_reg      = BRIGHTNESS_RST;
      one_cmp_reg     = ONE_CMP_RST;
      zero_cmp_reg    = ZERO_CMP_RST;
      reset_slots_reg = RESET_SLOTS_RST;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed rows with the reset register values.
      for (i = 0; i < NUM_ROWS; i++) begin
         send_request(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].red,
                      directed_rows[i].green, directed_rows[i].blue,
                      directed_rows[i].typed, directed_rows[i].compare_value);
      end
      wait_for_idle();

      // Random phases. The first two run at the register extremes; later
      // ones draw a fresh setting each, and every phase drains before the
      // registers change.
      phase      = 0;
      rand_items = 0;
      while (rand_items < RAND_ITEMS) begin
         if (phase == 0) begin
            program_regs(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
            idle_max = 11;
         end else if (phase == 1) begin
            program_regs(16'h5AFF, 16'h0000, 16'hFFFF, 16'hA5FF);
            idle_max = 0;
         end else begin
            program_regs(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                         pick_reg_value());
            idle_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
         end

         budget      = $urandom_range(50, 200);
         phase_items = 0;

         while (phase_items < budget && rand_items < RAND_ITEMS) begin
            sel = $urandom_range(0, 999);
            if (sel < 850) begin
               op = OP_SLOT;
            end else if (sel < 975) begin
               op = OP_WRITE;
            end else if (sel < 980) begin
               op = OP_CLEAR;
            end else begin
               op = OP_UNUSED;
            end
            idx = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, LED_COUNT - 1));
            send_request(op, idx, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 1'b0, 16'd0);
            rand_items++;
            phase_items++;
         end
         wait_for_idle();
         phase++;
      end

      $display("Run covered %0d slots (%0d in reset gaps), %0d pixel writes, %0d clears.",
               slot_count, gap_slot_count, write_count, clear_count);
      $display("%0d frames wrapped across %0d register settings; %0d mismatches.",
               wrap_count, setting_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
